// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the convolution core RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Expression must never be true out of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

// ----- hdl/v2dc_pkg.sv -----
// Shared types, constants and helper functions of the valid-region convolution core.
// No dependencies; every module of the core refers to this package by scoped names.
package v2dc_pkg;

	localparam int KERNEL_MAX_DEF = 4;
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int COEF_ROWS      = 4;
	localparam int COEF_W         = 16;
	localparam int SAMPLE_W       = 16;
	localparam int PROD_W         = 32;
	localparam int SUM_W          = 36;
	localparam int OUT_COL_W      = 10;
	localparam int OUT_ROW_W      = 12;
	localparam int OUT_TDATA_W    = 64;
	localparam int KSIZE_W        = 3;
	localparam int IWIDTH_W       = 11;
	localparam int CFG_DATA_W     = 64;
	localparam int CFG_INDEX_W    = 3;
	localparam int KSIZE_RESET    = 3;
	localparam int IWIDTH_RESET   = 8;
	localparam int ROW_LIMIT      = 4095;
	localparam int FIFO_DEPTH     = 8;

	typedef logic signed [SAMPLE_W-1:0]             sample_t;
	typedef logic signed [COEF_W-1:0]               coef_t;
	typedef logic signed [SUM_W-1:0]                sum_t;
	typedef logic [OUT_COL_W-1:0]                   ocol_t;
	typedef logic [OUT_ROW_W-1:0]                   orow_t;
	typedef logic [KSIZE_W-1:0]                     ksize_t;
	typedef logic [IWIDTH_W-1:0]                    iwidth_t;
	typedef logic [$clog2(COEF_ROWS)-1:0]           cidx_t;
	typedef logic [COEF_ROWS-1:0][CFG_DATA_W-1:0]   coef_rows_t;
	typedef logic [OUT_TDATA_W-1:0]                 out_tdata_t;

	// Per-item tag that rides along the MAC pipeline.
	typedef struct packed {
		logic  emit;
		ocol_t col;
		orow_t row;
	} meta_t;

	// One result; conv_sum sits in the lowest bits.
	typedef struct packed {
		orow_t row;
		ocol_t col;
		sum_t  sum;
	} out_item_t;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_KERNEL_SIZE = 3'd0,
		REG_IMAGE_WIDTH = 3'd1,
		REG_COEF_ROW0   = 3'd2,
		REG_COEF_ROW1   = 3'd3,
		REG_COEF_ROW2   = 3'd4,
		REG_COEF_ROW3   = 3'd5
	} cfg_reg_t;

	// Largest kernel side actually usable: coefficients exist for four rows only.
	function automatic int kw_of(int kmax);
		return (kmax < COEF_ROWS) ? kmax : COEF_ROWS;
	endfunction

	// Width of one line-memory word: all stored previous rows of one column.
	function automatic int line_w(int kmax);
		return ((kw_of(kmax) > 1) ? kw_of(kmax) - 1 : 1) * SAMPLE_W;
	endfunction

endpackage

// ----- hdl/v2dc_line_buffer.sv -----
// Line memory of the convolution core: one word per column holds the previous rows.
// Read-modify-write with last-write forwarding and a zeroing sweep after reset.
// Depends on v2dc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module v2dc_line_buffer #(
	parameter int KERNEL_MAX = v2dc_pkg::KERNEL_MAX_DEF,
	parameter int MAX_WIDTH  = v2dc_pkg::MAX_WIDTH_DEF,
	localparam int AW  = $clog2(MAX_WIDTH),
	localparam int LBW = v2dc_pkg::line_w(KERNEL_MAX)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req,
	input  logic [AW-1:0]        addr,
	input  v2dc_pkg::sample_t    sample,
	output logic                 clearing,
	output logic                 vld_s1,
	output v2dc_pkg::sample_t    sample_s1,
	output logic [LBW-1:0]       col_vec_s1
);

	typedef logic [AW-1:0]  addr_t;
	typedef logic [LBW-1:0] line_t;

	line_t mem_q [MAX_WIDTH];
	line_t rd_q;
	addr_t addr_s1;
	logic  clr_q;
	addr_t clr_addr_q;
	logic  wr_vld_q;
	addr_t wr_addr_q;
	line_t wr_data_q;

	logic  we;
	addr_t waddr;
	line_t wdata;
	line_t old_line;
	logic [LBW+v2dc_pkg::SAMPLE_W-1:0] shifted;

	always_comb begin
		// the most recent write is newer than what the read returned
		old_line = (wr_vld_q && (wr_addr_q == addr_s1)) ? wr_data_q : rd_q;
		shifted  = {old_line, sample_s1};
		if (clr_q) begin
			we    = 1'b1;
			waddr = clr_addr_q;
			wdata = '0;
		end else begin
			we    = vld_s1;
			waddr = addr_s1;
			wdata = shifted[LBW-1:0];
		end
	end

	assign col_vec_s1 = old_line;
	assign clearing   = clr_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (req) begin
			rd_q <= mem_q[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			addr_s1   <= addr;
			sample_s1 <= sample;
		end
		if (we) begin
			wr_addr_q <= waddr;
			wr_data_q <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			vld_s1     <= 1'b0;
			wr_vld_q   <= 1'b0;
		end else begin
			vld_s1   <= req;
			wr_vld_q <= wr_vld_q | we;
			if (clr_q) begin
				if (clr_addr_q == addr_t'(MAX_WIDTH - 1)) begin
					clr_q <= 1'b0;
				end
				clr_addr_q <= clr_addr_q + addr_t'(1);
			end
		end
	end

	`ASSERT_IMPLIES(a_no_req_in_clear, req, !clr_q, "request taken during line memory sweep")
	`ASSERT_IMPLIES(a_no_item_in_clear, vld_s1, !clr_q, "item in flight during line memory sweep")

endmodule

// ----- hdl/v2dc_window_mac.sv -----
// Window registers and multiply-accumulate pipeline of the convolution core.
// Shifts in one column per item, multiplies with the selected kernel, sums in two stages.
// Depends on v2dc_pkg.
module v2dc_window_mac #(
	parameter int KERNEL_MAX = v2dc_pkg::KERNEL_MAX_DEF,
	localparam int KW  = v2dc_pkg::kw_of(KERNEL_MAX),
	localparam int LBW = v2dc_pkg::line_w(KERNEL_MAX)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_s1,
	input  v2dc_pkg::meta_t       meta_s1,
	input  v2dc_pkg::sample_t     sample_s1,
	input  logic [LBW-1:0]        col_vec_s1,
	input  v2dc_pkg::ksize_t      k_eff,
	input  v2dc_pkg::coef_rows_t  coef,
	output logic                  push,
	output v2dc_pkg::out_item_t   item
);

	v2dc_pkg::sample_t win_q [KW][KW];
	v2dc_pkg::sample_t colv [KW];
	v2dc_pkg::coef_t   cf [KW][KW];
	logic signed [v2dc_pkg::PROD_W-1:0] prod_s3 [KW][KW];
	v2dc_pkg::sum_t    rsum_d [KW];
	v2dc_pkg::sum_t    rsum_s4 [KW];
	v2dc_pkg::sum_t    total;
	v2dc_pkg::meta_t   meta_s2, meta_s3, meta_s4;
	logic              vld_s2, vld_s3, vld_s4;
	logic [LBW+v2dc_pkg::SAMPLE_W-1:0] ext;

	// bottom window row takes the new sample, rows above take older lines
	always_comb begin
		ext = {col_vec_s1, sample_s1};
		for (int a = 0; a < KW; a++) begin
			colv[a] = ext[v2dc_pkg::SAMPLE_W*(KW-1-a) +: v2dc_pkg::SAMPLE_W];
		end
	end

	// kernel sits in the bottom-right corner of the window; zero the rest
	always_comb begin
		int off;
		v2dc_pkg::cidx_t ri;
		v2dc_pkg::cidx_t ci;
		off = KW - int'(k_eff);
		for (int a = 0; a < KW; a++) begin
			for (int b = 0; b < KW; b++) begin
				ri = v2dc_pkg::cidx_t'(a - off);
				ci = v2dc_pkg::cidx_t'(b - off);
				if ((a >= off) && (b >= off)) begin
					cf[a][b] = coef[ri][v2dc_pkg::COEF_W*ci +: v2dc_pkg::COEF_W];
				end else begin
					cf[a][b] = '0;
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < KW; a++) begin
			rsum_d[a] = '0;
			for (int b = 0; b < KW; b++) begin
				rsum_d[a] = rsum_d[a] + v2dc_pkg::sum_t'(prod_s3[a][b]);
			end
		end
		total = '0;
		for (int a = 0; a < KW; a++) begin
			total = total + rsum_s4[a];
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			meta_s2 <= meta_s1;
		end
		if (vld_s2) begin
			for (int a = 0; a < KW; a++) begin
				for (int b = 0; b < KW; b++) begin
					prod_s3[a][b] <= win_q[a][b] * cf[a][b];
				end
			end
			meta_s3 <= meta_s2;
		end
		if (vld_s3) begin
			rsum_s4 <= rsum_d;
			meta_s4 <= meta_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < KW; a++) begin
				for (int b = 0; b < KW; b++) begin
					win_q[a][b] <= '0;
				end
			end
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (vld_s1) begin
				for (int a = 0; a < KW; a++) begin
					for (int b = 0; b < KW - 1; b++) begin
						win_q[a][b] <= win_q[a][b+1];
					end
					win_q[a][KW-1] <= colv[a];
				end
			end
			vld_s2 <= vld_s1 && meta_s1.emit;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign push     = vld_s4;
	assign item.sum = total;
	assign item.col = meta_s4.col;
	assign item.row = meta_s4.row;

endmodule

// ----- hdl/v2dc_out_fifo.sv -----
// Result queue of the convolution core; decouples the MAC pipeline from the output stream.
// Depends on v2dc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module v2dc_out_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  v2dc_pkg::out_item_t  item_in,
	input  logic                 pop,
	output logic                 vld,
	output v2dc_pkg::out_item_t  item_out
);

	localparam int DEPTH = v2dc_pkg::FIFO_DEPTH;
	localparam int PW    = $clog2(DEPTH);

	typedef logic [PW-1:0] ptr_t;
	typedef logic [PW:0]   cnt_t;

	v2dc_pkg::out_item_t slot_q [DEPTH];
	ptr_t wr_ptr_q, rd_ptr_q;
	cnt_t cnt_q;
	logic full;
	logic do_pop;

	assign full     = (cnt_q == cnt_t'(DEPTH));
	assign vld      = (cnt_q != '0);
	assign do_pop   = pop && vld;
	assign item_out = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + ptr_t'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ptr_t'(1);
			end
			cnt_q <= cnt_q + cnt_t'(push) - cnt_t'(do_pop);
		end
	end

	`ASSERT_NEVER(a_no_push_when_full, push && full, "result pushed into full queue")

endmodule

// ----- hdl/valid_2d_convolution_core.sv -----
// Valid-region 2-D correlation core: takes one signed Q8.8 sample per request in raster
// order (tuser marks the first sample of a frame) and returns, for every position where a
// whole K x K window fits inside the image, the exact Q14.22 dot product with the kernel
// (no flip, no padding, no rounding) together with its column and row in the valid output.
// Throughput is one sample per clock while s_axis_tready is high. Each result passes the
// line memory read register and the MAC stages s2 to s4 into the output queue, and results
// leave in order. The rate is set by the line memory, one registered read and one write
// back per sample, whose word holds all stored rows of one column. After reset the line
// memory is swept to zero, one column per cycle; s_axis_tready stays low for that time
// while configuration writes are still taken. Input is also held off while FIFO_DEPTH
// results are outstanding in the pipeline and the output queue. Write kernel size, image
// width and coefficients only while no sample is in flight.
// Depends on v2dc_pkg, v2dc_line_buffer, v2dc_window_mac, v2dc_out_fifo, assert_macros.svh.
`include "assert_macros.svh"

module valid_2d_convolution_core #(
	parameter int KERNEL_MAX = v2dc_pkg::KERNEL_MAX_DEF,
	parameter int MAX_WIDTH  = v2dc_pkg::MAX_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// input stream
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	input  logic [v2dc_pkg::SAMPLE_W-1:0]         s_axis_tdata,   // [15:0] sample
	input  logic [0:0]                            s_axis_tuser,   // [0] frame_start
	// result stream
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	output logic [v2dc_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,   // [35:0] conv_sum,
	                                                              // [45:36] out_col,
	                                                              // [57:46] out_row
	// configuration write port
	input  logic                                  cfg_we,
	input  logic [v2dc_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [v2dc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	localparam int KW  = v2dc_pkg::kw_of(KERNEL_MAX);
	localparam int CW  = $clog2(MAX_WIDTH);
	localparam int LBW = v2dc_pkg::line_w(KERNEL_MAX);
	localparam int UW  = $clog2(v2dc_pkg::FIFO_DEPTH + 1);

	typedef logic [CW-1:0] col_t;
	typedef logic [CW:0]   wcnt_t;
	typedef logic [UW-1:0] used_t;

	// configuration registers
	v2dc_pkg::ksize_t     ksize_q;
	v2dc_pkg::iwidth_t    iwidth_q;
	v2dc_pkg::coef_rows_t coef_q;

	// position counters: column and row of the next sample
	col_t            col_q;
	v2dc_pkg::orow_t row_q;
	used_t           used_q;

	v2dc_pkg::ksize_t k_eff, km1;
	wcnt_t            w_eff;
	col_t             cur_col;
	v2dc_pkg::orow_t  cur_row;
	logic             emit0;
	logic             col_last;
	logic             acc;
	logic             pop;
	v2dc_pkg::meta_t  meta_s1;

	logic                 lb_clearing;
	logic                 lb_vld;
	v2dc_pkg::sample_t    lb_sample;
	logic [LBW-1:0]       lb_col_vec;
	logic                 mac_push;
	v2dc_pkg::out_item_t  mac_item;
	v2dc_pkg::out_item_t  fifo_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q  <= v2dc_pkg::ksize_t'(v2dc_pkg::KSIZE_RESET);
			iwidth_q <= v2dc_pkg::iwidth_t'(v2dc_pkg::IWIDTH_RESET);
			coef_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				v2dc_pkg::REG_KERNEL_SIZE: ksize_q  <= cfg_data[v2dc_pkg::KSIZE_W-1:0];
				v2dc_pkg::REG_IMAGE_WIDTH: iwidth_q <= cfg_data[v2dc_pkg::IWIDTH_W-1:0];
				v2dc_pkg::REG_COEF_ROW0:   coef_q[0] <= cfg_data;
				v2dc_pkg::REG_COEF_ROW1:   coef_q[1] <= cfg_data;
				v2dc_pkg::REG_COEF_ROW2:   coef_q[2] <= cfg_data;
				v2dc_pkg::REG_COEF_ROW3:   coef_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp kernel size into 1..KW and width into 1..MAX_WIDTH.
	always_comb begin
		k_eff = ksize_q;
		if (ksize_q == '0) begin
			k_eff = v2dc_pkg::ksize_t'(1);
		end else if (ksize_q > v2dc_pkg::ksize_t'(KW)) begin
			k_eff = v2dc_pkg::ksize_t'(KW);
		end
		km1 = k_eff - v2dc_pkg::ksize_t'(1);

		if (iwidth_q == '0) begin
			w_eff = wcnt_t'(1);
		end else if (int'(iwidth_q) > MAX_WIDTH) begin
			w_eff = wcnt_t'(MAX_WIDTH);
		end else begin
			w_eff = wcnt_t'(iwidth_q);
		end
	end

	// Frame start clears the position before the sample is placed.
	always_comb begin
		cur_col  = s_axis_tuser[0] ? '0 : col_q;
		cur_row  = s_axis_tuser[0] ? '0 : row_q;
		emit0    = (cur_row >= v2dc_pkg::orow_t'(km1)) && (cur_col >= col_t'(km1));
		// a column at or past the last one ends the row, also after a width drop
		col_last = (wcnt_t'(cur_col) + wcnt_t'(1)) >= w_eff;
	end

	assign s_axis_tready = !lb_clearing && (used_q < used_t'(v2dc_pkg::FIFO_DEPTH));
	assign acc           = s_axis_tvalid && s_axis_tready;
	assign pop           = m_axis_tvalid && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			used_q <= '0;
		end else begin
			if (acc) begin
				if (col_last) begin
					col_q <= '0;
					// hold the row at its limit instead of wrapping
					if (cur_row != v2dc_pkg::orow_t'(v2dc_pkg::ROW_LIMIT)) begin
						row_q <= cur_row + v2dc_pkg::orow_t'(1);
					end else begin
						row_q <= cur_row;
					end
				end else begin
					col_q <= cur_col + col_t'(1);
					row_q <= cur_row;
				end
			end
			// count results promised but not yet taken at the output
			used_q <= used_q + used_t'(acc && emit0) - used_t'(pop);
		end
	end

	// tag of the sample, taken along with the line memory read
	always_ff @(posedge clk) begin
		if (acc) begin
			meta_s1.emit <= emit0;
			meta_s1.col  <= v2dc_pkg::ocol_t'(cur_col - col_t'(km1));
			meta_s1.row  <= cur_row - v2dc_pkg::orow_t'(km1);
		end
	end

	v2dc_line_buffer #(
		.KERNEL_MAX (KERNEL_MAX),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_line_buffer (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (acc),
		.addr       (cur_col),
		.sample     (v2dc_pkg::sample_t'(s_axis_tdata)),
		.clearing   (lb_clearing),
		.vld_s1     (lb_vld),
		.sample_s1  (lb_sample),
		.col_vec_s1 (lb_col_vec)
	);

	v2dc_window_mac #(
		.KERNEL_MAX (KERNEL_MAX)
	) u_window_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.vld_s1     (lb_vld),
		.meta_s1    (meta_s1),
		.sample_s1  (lb_sample),
		.col_vec_s1 (lb_col_vec),
		.k_eff      (k_eff),
		.coef       (coef_q),
		.push       (mac_push),
		.item       (mac_item)
	);

	v2dc_out_fifo u_out_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (mac_push),
		.item_in    (mac_item),
		.pop        (m_axis_tready),
		.vld        (m_axis_tvalid),
		.item_out   (fifo_item)
	);

	assign m_axis_tdata = v2dc_pkg::out_tdata_t'(fifo_item);

	`ASSERT_IMPLIES(a_result_was_counted, m_axis_tvalid, used_q != '0, "result without credit")
	`ASSERT_IMPLIES(a_no_push_without_credit, mac_push, used_q != '0, "push without credit")

endmodule
